/* design/bcmp_pkg.sv */
package bcmp_pkg;

  // Width of the signed pressure datapath and of the long divider.
  localparam int unsigned DivW = 64;
  // Width of one raw conversion result.
  localparam int unsigned RawW = 20;

  typedef enum logic [1:0] {
    CfgTempCoef      = 2'd0,
    CfgPressCoefLow  = 2'd1,
    CfgPressCoefHigh = 2'd2,
    CfgPressCoefNine = 2'd3
  } cfg_idx_e;

  // Temperature results that ride along the pressure pipeline.
  typedef struct packed {
    logic signed [31:0] temp;
    logic signed [31:0] fine;
  } temp_side_t;

  // Sideband of the divider: temperature results, zero denominator, quotient sign.
  typedef struct packed {
    temp_side_t tv;
    logic       zero;
    logic       neg;
  } div_side_t;

endpackage

/* design/bcmp_cfg_if.sv */
interface bcmp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* design/bcmp_in_if.sv */
interface bcmp_in_if;
  logic                      valid;
  logic                      ready;
  logic [bcmp_pkg::RawW-1:0] raw_temperature;
  logic [bcmp_pkg::RawW-1:0] raw_pressure;

  modport source (output valid, output raw_temperature, output raw_pressure, input ready);
  modport sink (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

/* design/bcmp_out_if.sv */
interface bcmp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] temperature_centi;
  logic signed [31:0] fine_temperature;
  logic [31:0]        pressure_pa;
  logic               pressure_invalid;

  modport source (output valid, output temperature_centi, output fine_temperature,
                  output pressure_pa, output pressure_invalid, input ready);
  modport sink (input valid, input temperature_centi, input fine_temperature,
                input pressure_pa, input pressure_invalid, output ready);
endinterface

/* design/bcmp_div.sv */
module bcmp_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [bcmp_pkg::DivW-1:0] dividend_i,
  input  logic [bcmp_pkg::DivW-1:0] divisor_i,
  input  bcmp_pkg::div_side_t       side_i,
  output logic                      valid_o,
  output logic [bcmp_pkg::DivW-1:0] quotient_o,
  output bcmp_pkg::div_side_t       side_o
);
  import bcmp_pkg::*;

  // Restoring division of magnitudes, one quotient bit per stage.
  logic            vld_q  [DivW];
  logic [DivW-1:0] rem_q  [DivW];
  logic [DivW-1:0] quo_q  [DivW];
  logic [DivW-1:0] den_q  [DivW];
  div_side_t       side_q [DivW];

  logic            vld_in  [DivW];
  logic [DivW-1:0] rem_in  [DivW];
  logic [DivW-1:0] quo_in  [DivW];
  logic [DivW-1:0] den_in  [DivW];
  div_side_t       side_in [DivW];

  for (genvar k = 0; k < DivW; k++) begin : g_step
    logic [DivW-1:0] sh;
    logic [DivW-1:0] diff;
    logic            ge;

    if (k == 0) begin : g_first
      assign vld_in[k]  = valid_i;
      assign rem_in[k]  = '0;
      assign quo_in[k]  = dividend_i;
      assign den_in[k]  = divisor_i;
      assign side_in[k] = side_i;
    end else begin : g_next
      assign vld_in[k]  = vld_q[k-1];
      assign rem_in[k]  = rem_q[k-1];
      assign quo_in[k]  = quo_q[k-1];
      assign den_in[k]  = den_q[k-1];
      assign side_in[k] = side_q[k-1];
    end

    // The partial remainder stays below the divisor, so its top bit is always clear.
    assign sh   = {rem_in[k][DivW-2:0], quo_in[k][DivW-1]};
    assign ge   = (sh >= den_in[k]);
    assign diff = sh - den_in[k];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? diff : sh;
        quo_q[k]  <= {quo_in[k][DivW-2:0], ge};
        den_q[k]  <= den_in[k];
        side_q[k] <= side_in[k];
      end
    end
  end

  assign valid_o    = vld_q[DivW-1];
  assign quotient_o = quo_q[DivW-1];
  assign side_o     = side_q[DivW-1];

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[DivW-1] && (den_q[DivW-1] != '0) |-> rem_q[DivW-1] < den_q[DivW-1])
    else $error("divider remainder not below divisor");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && valid_i |=> vld_q[0])
    else $error("divider lost an item at entry");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i && valid_o |=> valid_o && $stable(quotient_o))
    else $error("divider output moved during a stall");

endmodule

/* design/barometric_sensor_compensation_core.sv */
// Channel | Dir | Payload                                                   | Handshake
// cfg_i   | in  | index (2b), data (64b)                                    | valid/ready
// in_i    | in  | raw_temperature (20b), raw_pressure (20b)                 | valid/ready
// out_o   | out | temperature_centi, fine_temperature, pressure_pa, invalid | valid/ready
//
// One item enters per cycle unless out_o stalls; each item passes from
// acceptance to its result through 13 front stages, the 64-stage divider (one
// quotient bit per stage), 7 back stages and the output register.
// Reset clears the valid bits and the coefficient registers to zero.
// A stall on out_o freezes every stage at once, so in_i.ready drops only when
// the output register holds an item that is not taken.
module barometric_sensor_compensation_core (
  input logic         clk_i,
  input logic         rst_ni,
  bcmp_cfg_if.sink    cfg_i,
  bcmp_in_if.sink     in_i,
  bcmp_out_if.source  out_o
);
  import bcmp_pkg::*;

  localparam int unsigned FrontN = 13;
  localparam int unsigned BackN  = 7;

  // Low 32 bits of a 32-bit slice times a signed coefficient, exact.
  function automatic logic signed [49:0] mul_lo(input logic [31:0] x,
                                                input logic signed [16:0] c);
    return $signed({1'b0, x}) * c;
  endfunction

  // Upper slice times the coefficient; only its low 32 bits reach the result.
  function automatic logic [31:0] mul_hi(input logic [31:0] x, input logic signed [16:0] c);
    return x * 32'(c);
  endfunction

  // Joins the two partial products into the product modulo 2^64.
  function automatic logic [63:0] mul_join(input logic signed [49:0] lo, input logic [31:0] hi);
    return 64'(lo) + {hi, 32'd0};
  endfunction

  function automatic logic signed [16:0] sc17(input logic [15:0] v);
    return $signed({v[15], v});
  endfunction

  // ---------------------------------------------------------------------------
  // Calibration registers. Writes are always accepted.
  // ---------------------------------------------------------------------------
  logic [47:0] tco_q;
  logic [63:0] pcl_q;
  logic [63:0] pch_q;
  logic [15:0] p9_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tco_q <= '0;
      pcl_q <= '0;
      pch_q <= '0;
      p9_q  <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CfgTempCoef:      tco_q <= cfg_i.data[47:0];
        CfgPressCoefLow:  pcl_q <= cfg_i.data;
        CfgPressCoefHigh: pch_q <= cfg_i.data;
        CfgPressCoefNine: p9_q  <= cfg_i.data[15:0];
        default: ;
      endcase
    end
  end

  logic [15:0]        t1_w, p1_w;
  logic signed [15:0] t2_w, t3_w, p2_w, p3_w, p4_w, p5_w, p6_w, p7_w, p8_w, p9_w;

  assign t1_w = tco_q[15:0];
  assign t2_w = $signed(tco_q[31:16]);
  assign t3_w = $signed(tco_q[47:32]);
  assign p1_w = pcl_q[15:0];
  assign p2_w = $signed(pcl_q[31:16]);
  assign p3_w = $signed(pcl_q[47:32]);
  assign p4_w = $signed(pcl_q[63:48]);
  assign p5_w = $signed(pch_q[15:0]);
  assign p6_w = $signed(pch_q[31:16]);
  assign p7_w = $signed(pch_q[47:32]);
  assign p8_w = $signed(pch_q[63:48]);
  assign p9_w = $signed(p9_q);

  // ---------------------------------------------------------------------------
  // Flow control: the whole pipe advances unless the output is held.
  // ---------------------------------------------------------------------------
  logic             out_v_q;
  logic             adv;
  logic [FrontN:1]  fv_q;
  logic [BackN:1]   bv_q;
  logic             div_v;

  assign adv        = !out_v_q || out_o.ready;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q    <= '0;
      bv_q    <= '0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      fv_q    <= {fv_q[FrontN-1:1], in_i.valid};
      bv_q    <= {bv_q[BackN-1:1], div_v};
      out_v_q <= bv_q[BackN];
    end
  end

  // ---------------------------------------------------------------------------
  // Front stages: temperature, then the pressure numerator and denominator.
  // ---------------------------------------------------------------------------
  logic [RawW-1:0]    ap_q [1:9];
  temp_side_t         ts_q [5:FrontN];

  logic signed [18:0] s1_d1_q;
  logic signed [17:0] s1_d2_q;
  logic signed [34:0] s2_m1_q;
  logic signed [35:0] s2_m2_q;
  logic signed [20:0] s3_ta_q;
  logic signed [35:0] s3_m3_q;
  logic signed [31:0] s4_fine_q;
  logic signed [32:0] s5_a_q;
  logic signed [63:0] s6_aa_q;
  logic signed [48:0] s6_ap5_q, s6_ap2_q, s7_ap5_q, s7_ap2_q, s8_ap5_q, s8_ap2_q;
  logic signed [49:0] s7_p6lo_q, s7_p3lo_q;
  logic [31:0]        s7_p6hi_q, s7_p3hi_q;
  logic signed [63:0] s8_aap6_q, s8_aap3_q;
  logic signed [63:0] s9_b_q, s9_a2_q;
  logic signed [63:0] s10_x_q, s10_num_q;
  logic signed [49:0] s11_xlo_q, s11_nlo_q;
  logic [31:0]        s11_xhi_q, s11_nhi_q;
  logic signed [63:0] s12_den_q, s12_num_q;
  logic [DivW-1:0]    s13_an_q, s13_ad_q;
  logic               s13_zero_q, s13_neg_q;

  logic signed [31:0] m1_sh, m2_sh, m3_sh, f5_w, temp_sh;
  logic signed [19:0] sq_w;
  logic signed [17:0] tb_w;
  logic signed [65:0] aa_full;
  logic signed [63:0] aap3_sh, b_w, a2_w, num0_w, xj_w, den_w;
  logic [20:0]        pw_w;

  assign m1_sh   = $signed(s2_m1_q[31:0]) >>> 11;
  assign m2_sh   = $signed(s2_m2_q[31:0]) >>> 12;
  assign sq_w    = m2_sh[19:0];
  assign m3_sh   = $signed(s3_m3_q[31:0]) >>> 14;
  assign tb_w    = m3_sh[17:0];
  assign f5_w    = (s4_fine_q <<< 2) + s4_fine_q + 32'sd128;
  assign temp_sh = f5_w >>> 8;
  assign aa_full = s5_a_q * s5_a_q;
  assign aap3_sh = s8_aap3_q >>> 8;
  assign b_w     = s8_aap6_q + (64'(s8_ap5_q) <<< 17) + (64'(p4_w) <<< 35);
  assign a2_w    = aap3_sh + (64'(s8_ap2_q) <<< 12);
  assign pw_w    = 21'd1048576 - {1'b0, ap_q[9]};
  assign num0_w  = ($signed({43'd0, pw_w}) <<< 31) - s9_b_q;
  assign xj_w    = $signed(mul_join(s11_xlo_q, s11_xhi_q));
  assign den_w   = xj_w >>> 33;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ap_q[1] <= in_i.raw_pressure;
      for (int k = 2; k <= 9; k++) begin
        ap_q[k] <= ap_q[k-1];
      end
      // Stage 1: temperature differences.
      s1_d1_q <= $signed({2'b00, in_i.raw_temperature[19:3]}) - $signed({2'b00, t1_w, 1'b0});
      s1_d2_q <= $signed({2'b00, in_i.raw_temperature[19:4]}) - $signed({2'b00, t1_w});
      // Stage 2: first products.
      s2_m1_q <= s1_d1_q * t2_w;
      s2_m2_q <= s1_d2_q * s1_d2_q;
      // Stage 3: first term and the square times T3.
      s3_ta_q <= m1_sh[20:0];
      s3_m3_q <= sq_w * t3_w;
      // Stage 4: fine temperature.
      s4_fine_q <= 32'(s3_ta_q) + 32'(tb_w);
      // Stage 5: temperature in hundredths and the pressure offset.
      ts_q[5].temp <= temp_sh;
      ts_q[5].fine <= s4_fine_q;
      s5_a_q       <= 33'(s4_fine_q) - 33'sd128000;
      for (int k = 6; k <= FrontN; k++) begin
        ts_q[k] <= ts_q[k-1];
      end
      // Stage 6: square of the offset and the linear products.
      s6_aa_q  <= aa_full[63:0];
      s6_ap5_q <= s5_a_q * p5_w;
      s6_ap2_q <= s5_a_q * p2_w;
      // Stage 7: the square times P6 and P3, as partial products.
      s7_p6lo_q <= mul_lo(s6_aa_q[31:0], sc17(p6_w));
      s7_p6hi_q <= mul_hi(s6_aa_q[63:32], sc17(p6_w));
      s7_p3lo_q <= mul_lo(s6_aa_q[31:0], sc17(p3_w));
      s7_p3hi_q <= mul_hi(s6_aa_q[63:32], sc17(p3_w));
      s7_ap5_q  <= s6_ap5_q;
      s7_ap2_q  <= s6_ap2_q;
      // Stage 8: join the partial products.
      s8_aap6_q <= $signed(mul_join(s7_p6lo_q, s7_p6hi_q));
      s8_aap3_q <= $signed(mul_join(s7_p3lo_q, s7_p3hi_q));
      s8_ap5_q  <= s7_ap5_q;
      s8_ap2_q  <= s7_ap2_q;
      // Stage 9: the numerator offset and the denominator sum.
      s9_b_q  <= b_w;
      s9_a2_q <= a2_w;
      // Stage 10: denominator bias and raw numerator.
      s10_x_q   <= 64'sh0000_8000_0000_0000 + s9_a2_q;
      s10_num_q <= num0_w;
      // Stage 11: scale by P1 and by 3125.
      s11_xlo_q <= mul_lo(s10_x_q[31:0], $signed({1'b0, p1_w}));
      s11_xhi_q <= mul_hi(s10_x_q[63:32], $signed({1'b0, p1_w}));
      s11_nlo_q <= mul_lo(s10_num_q[31:0], 17'sd3125);
      s11_nhi_q <= mul_hi(s10_num_q[63:32], 17'sd3125);
      // Stage 12: finished numerator and denominator.
      s12_den_q <= den_w;
      s12_num_q <= $signed(mul_join(s11_nlo_q, s11_nhi_q));
      // Stage 13: magnitudes and sign for the divider.
      s13_zero_q <= (s12_den_q == 64'sd0);
      s13_neg_q  <= s12_num_q[63] ^ s12_den_q[63];
      s13_an_q   <= s12_num_q[63] ? 64'(-s12_num_q) : 64'(s12_num_q);
      s13_ad_q   <= s12_den_q[63] ? 64'(-s12_den_q) : 64'(s12_den_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Divider. A zero denominator runs through and is masked at the output.
  // ---------------------------------------------------------------------------
  div_side_t       div_side_in, div_side_out;
  logic [DivW-1:0] div_q;

  assign div_side_in.tv   = ts_q[FrontN];
  assign div_side_in.zero = s13_zero_q;
  assign div_side_in.neg  = s13_neg_q;

  bcmp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .valid_i    (fv_q[FrontN]),
    .dividend_i (s13_an_q),
    .divisor_i  (s13_ad_q),
    .side_i     (div_side_in),
    .valid_o    (div_v),
    .quotient_o (div_q),
    .side_o     (div_side_out)
  );

  // ---------------------------------------------------------------------------
  // Back stages: quadratic and linear corrections, then the final divide by 256.
  // ---------------------------------------------------------------------------
  div_side_t          bs_q [1:BackN];
  logic signed [63:0] e1_p_q, e2_p_q, e3_p_q, e4_p_q, e5_p_q;
  logic [63:0]        e2_sql_q;
  logic [31:0]        e2_sqx_q;
  logic signed [49:0] e2_elo_q, e4_clo_q;
  logic [31:0]        e2_ehi_q, e4_chi_q;
  logic [63:0]        e3_pss_q;
  logic signed [63:0] e3_e_q, e4_e_q, e5_e_q, e5_c_q;
  logic signed [63:0] e6_s_q, e7_r_q;

  logic signed [63:0] ps_w, ej_w, e_sh, cj_w, c_sh, s_sh, rp_w, qn_w, qp_w, pres_w;
  logic [31:0]        out_temp_q, out_fine_q, out_pres_q;
  logic               out_inv_q;

  assign ps_w   = e1_p_q >>> 13;
  assign ej_w   = $signed(mul_join(e2_elo_q, e2_ehi_q));
  assign e_sh   = ej_w >>> 19;
  assign cj_w   = $signed(mul_join(e4_clo_q, e4_chi_q));
  assign c_sh   = cj_w >>> 25;
  assign s_sh   = e6_s_q >>> 8;
  // Divide by 256 toward zero: negative values are biased before the shift.
  assign rp_w   = e7_r_q + 64'sd255;
  assign qn_w   = rp_w >>> 8;
  assign qp_w   = e7_r_q >>> 8;
  assign pres_w = e7_r_q[63] ? qn_w : qp_w;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      bs_q[1] <= div_side_out;
      for (int k = 2; k <= BackN; k++) begin
        bs_q[k] <= bs_q[k-1];
      end
      // Stage E1: signed quotient.
      e1_p_q <= div_side_out.neg ? $signed(-div_q) : $signed(div_q);
      // Stage E2: square of the scaled quotient and the P8 product, in halves.
      e2_sql_q <= {32'd0, ps_w[31:0]} * {32'd0, ps_w[31:0]};
      e2_sqx_q <= ps_w[31:0] * ps_w[63:32];
      e2_elo_q <= mul_lo(e1_p_q[31:0], sc17(p8_w));
      e2_ehi_q <= mul_hi(e1_p_q[63:32], sc17(p8_w));
      e2_p_q   <= e1_p_q;
      // Stage E3: the square modulo 2^64 and the linear correction.
      e3_pss_q <= e2_sql_q + {e2_sqx_q[30:0], 33'd0};
      e3_e_q   <= e_sh;
      e3_p_q   <= e2_p_q;
      // Stage E4: the square times P9.
      e4_clo_q <= mul_lo(e3_pss_q[31:0], sc17(p9_w));
      e4_chi_q <= mul_hi(e3_pss_q[63:32], sc17(p9_w));
      e4_e_q   <= e3_e_q;
      e4_p_q   <= e3_p_q;
      // Stage E5: quadratic correction.
      e5_c_q <= c_sh;
      e5_e_q <= e4_e_q;
      e5_p_q <= e4_p_q;
      // Stage E6: corrected pressure.
      e6_s_q <= e5_p_q + e5_c_q + e5_e_q;
      // Stage E7: scale down and add the P7 offset.
      e7_r_q <= s_sh + (64'(p7_w) <<< 4);
      // Output register.
      out_temp_q <= bs_q[BackN].tv.temp;
      out_fine_q <= bs_q[BackN].tv.fine;
      out_inv_q  <= bs_q[BackN].zero;
      out_pres_q <= bs_q[BackN].zero ? 32'd0 : pres_w[31:0];
    end
  end

  assign out_o.valid             = out_v_q;
  assign out_o.temperature_centi = $signed(out_temp_q);
  assign out_o.fine_temperature  = $signed(out_fine_q);
  assign out_o.pressure_pa       = out_pres_q;
  assign out_o.pressure_invalid  = out_inv_q;

  // The temperature leaving the block must still match its own fine temperature.
  logic signed [31:0] chk_f5, chk_temp;
  assign chk_f5   = ($signed(out_fine_q) <<< 2) + $signed(out_fine_q) + 32'sd128;
  assign chk_temp = chk_f5 >>> 8;

  a_temp_matches_fine: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> $signed(out_temp_q) == chk_temp)
    else $error("temperature and fine temperature out of step");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_inv_q |-> out_pres_q == 32'd0)
    else $error("invalid pressure item carries a nonzero pressure");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> fv_q[1])
    else $error("accepted item did not enter the pipeline");

  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(fv_q) && $stable(bv_q))
    else $error("pipeline moved during a stall");

endmodule
